// File: hw/rtl/touch_sample_conditioner_top_assert.svh
// Assertion macros used by the touch sample conditioner checker.
`ifndef TOUCH_SAMPLE_CONDITIONER_TOP_ASSERT_SVH
`define TOUCH_SAMPLE_CONDITIONER_TOP_ASSERT_SVH

// Same-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define TSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on i_clk, off while i_rst_n is low.
`define TSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/tsc_pkg.sv
// Shared types, register map and constants of the touch sample conditioner.
package tsc_pkg;

    localparam int SAMPLE_BITS_DEF = 12;
    localparam int QUEUE_DEPTH_DEF = 2;

    localparam int POINT_BITS    = 12;
    localparam int LIMIT_BITS    = 12;
    localparam int GAIN_BITS     = 16;
    localparam int SCALE_SHIFT   = 16;
    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;
    localparam int ROUNDS        = 3;

    // Register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_PRESSURE_LIMIT = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_X_GAIN         = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_Y_GAIN         = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_X_LIMIT        = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_Y_LIMIT        = 3'd4;

    // Reset values
    localparam logic [LIMIT_BITS-1:0] PRESSURE_LIMIT_RST = 12'd3800;
    localparam logic [GAIN_BITS-1:0]  X_GAIN_RST         = 16'd4063;
    localparam logic [GAIN_BITS-1:0]  Y_GAIN_RST         = 16'd5505;
    localparam logic [LIMIT_BITS-1:0] X_LIMIT_RST        = 12'd240;
    localparam logic [LIMIT_BITS-1:0] Y_LIMIT_RST        = 12'd320;

    typedef struct packed {
        logic [LIMIT_BITS-1:0] pressure_limit;
        logic [GAIN_BITS-1:0]  x_gain;
        logic [GAIN_BITS-1:0]  y_gain;
        logic [LIMIT_BITS-1:0] x_limit;
        logic [LIMIT_BITS-1:0] y_limit;
    } t_cfg;

endpackage

// File: hw/rtl/tsc_front.sv
// Front pipeline: sums the three rounds, divides by three and classifies touch.
module tsc_front
    import tsc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_stall,
    input  logic [3:0][ROUNDS-1:0][SAMPLE_BITS-1:0] i_samples,
    input  t_cfg                                  i_cfg,
    input  logic                                  i_q_full,
    output logic                                  o_push,
    output logic [SAMPLE_BITS-1:0]                o_ax,
    output logic [SAMPLE_BITS-1:0]                o_ay,
    output logic                                  o_touch
);

    localparam int SUM_BITS = SAMPLE_BITS + 2;
    localparam int PROD_BITS = 2 * SUM_BITS;
    localparam int DIVISOR = 3;
    localparam logic [SUM_BITS-1:0] DIV3_MUL = SUM_BITS'((2 ** SUM_BITS) / DIVISOR);
    localparam int CMP_BITS = (SAMPLE_BITS > LIMIT_BITS) ? SAMPLE_BITS : LIMIT_BITS;

    // Quantity order: 0 X, 1 Y, 2 Z1, 3 Z2
    logic                   r_a_vld;
    logic [SUM_BITS-1:0]    r_a_sum [4];
    logic                   r_b_vld;
    logic [SUM_BITS-1:0]    r_b_sum [4];
    logic [SAMPLE_BITS-1:0] r_b_q0  [4];
    logic                   r_c_vld;
    logic [SAMPLE_BITS-1:0] r_c_ax;
    logic [SAMPLE_BITS-1:0] r_c_ay;
    logic                   r_c_touch;

    logic [SUM_BITS-1:0]    w_in_sum [4];
    logic [PROD_BITS-1:0]   w_prod   [4];
    logic [SUM_BITS-1:0]    w_tq     [4];
    logic [SUM_BITS-1:0]    w_rem    [4];
    logic [SAMPLE_BITS-1:0] w_avg    [4];
    logic [SAMPLE_BITS-1:0] w_diff;
    logic                   w_touch;
    logic                   w_a_rdy;
    logic                   w_b_rdy;
    logic                   w_c_rdy;

    assign w_c_rdy = !r_c_vld || !i_q_full;
    assign w_b_rdy = !r_b_vld || w_c_rdy;
    assign w_a_rdy = !r_a_vld || w_b_rdy;
    assign o_stall = !w_a_rdy;
    assign o_push  = r_c_vld && !i_q_full;

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_in_sum[k] = SUM_BITS'(i_samples[k][0]) + SUM_BITS'(i_samples[k][1])
                        + SUM_BITS'(i_samples[k][2]);
            // reciprocal estimate is exact or one short
            w_prod[k] = PROD_BITS'(r_a_sum[k]) * PROD_BITS'(DIV3_MUL);
            w_tq[k]   = SUM_BITS'({r_b_q0[k], 1'b0}) + SUM_BITS'(r_b_q0[k]);
            w_rem[k]  = r_b_sum[k] - w_tq[k];
            w_avg[k]  = r_b_q0[k] + SAMPLE_BITS'(w_rem[k] >= SUM_BITS'(DIVISOR));
        end
    end

    assign w_diff  = (w_avg[2] >= w_avg[3]) ? (w_avg[2] - w_avg[3]) : (w_avg[3] - w_avg[2]);
    assign w_touch = CMP_BITS'(w_diff) < CMP_BITS'(i_cfg.pressure_limit);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else begin
            if (w_a_rdy) begin
                r_a_vld <= i_valid;
            end
            if (w_b_rdy) begin
                r_b_vld <= r_a_vld;
            end
            if (w_c_rdy) begin
                r_c_vld <= r_b_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_a_rdy && i_valid) begin
            for (int k = 0; k < 4; k++) begin
                r_a_sum[k] <= w_in_sum[k];
            end
        end
        if (w_b_rdy && r_a_vld) begin
            for (int k = 0; k < 4; k++) begin
                r_b_sum[k] <= r_a_sum[k];
                r_b_q0[k]  <= SAMPLE_BITS'(w_prod[k][PROD_BITS-1:SUM_BITS]);
            end
        end
        if (w_c_rdy && r_b_vld) begin
            r_c_ax    <= w_avg[0];
            r_c_ay    <= w_avg[1];
            r_c_touch <= w_touch;
        end
    end

    assign o_ax    = r_c_ax;
    assign o_ay    = r_c_ay;
    assign o_touch = r_c_touch;

endmodule

// File: hw/rtl/tsc_queue.sv
// Short FIFO between the classifying front and the scaling back.
module tsc_queue
    import tsc_pkg::*;
#(
    parameter int WIDTH = 2 * SAMPLE_BITS_DEF + 1,
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr;
    logic [CNT_BITS-1:0] r_count;
    logic [PTR_BITS-1:0] n_wr_ptr;
    logic [PTR_BITS-1:0] n_rd_ptr;

    assign o_full  = (r_count == CNT_BITS'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    assign n_wr_ptr = (r_wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign n_rd_ptr = (r_rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// File: hw/rtl/tsc_back.sv
// Back pipeline: scales and clamps the position, keeps the held point, drives results.
module tsc_back
    import tsc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_pop,
    input  logic [SAMPLE_BITS-1:0] i_ax,
    input  logic [SAMPLE_BITS-1:0] i_ay,
    input  logic                   i_touch,
    input  t_cfg                   i_cfg,
    output logic                   o_valid,
    input  logic                   i_stall,
    output logic [POINT_BITS-1:0]  o_point_x,
    output logic [POINT_BITS-1:0]  o_point_y,
    output logic                   o_pressed
);

    localparam int PROD_BITS = SAMPLE_BITS + GAIN_BITS;
    localparam int CMP_BITS = (SAMPLE_BITS > LIMIT_BITS) ? SAMPLE_BITS : LIMIT_BITS;

    logic                   r_p_vld;
    logic [PROD_BITS-1:0]   r_p_prod_x;
    logic [PROD_BITS-1:0]   r_p_prod_y;
    logic                   r_p_touch;
    logic                   r_o_vld;
    logic [POINT_BITS-1:0]  r_held_x;
    logic [POINT_BITS-1:0]  r_held_y;
    logic                   r_pressed;

    logic                   w_p_rdy;
    logic                   w_o_rdy;
    logic [SAMPLE_BITS-1:0] w_sx;
    logic [SAMPLE_BITS-1:0] w_sy;
    logic [POINT_BITS-1:0]  w_cx;
    logic [POINT_BITS-1:0]  w_cy;

    assign w_o_rdy = !r_o_vld || !i_stall;
    assign w_p_rdy = !r_p_vld || w_o_rdy;
    assign o_pop   = i_valid && w_p_rdy;

    // drop the Q0.16 fraction, then clamp to the limit
    assign w_sx = r_p_prod_x[PROD_BITS-1:SCALE_SHIFT];
    assign w_sy = r_p_prod_y[PROD_BITS-1:SCALE_SHIFT];
    assign w_cx = (CMP_BITS'(w_sx) > CMP_BITS'(i_cfg.x_limit)) ?
                  POINT_BITS'(i_cfg.x_limit) : POINT_BITS'(w_sx);
    assign w_cy = (CMP_BITS'(w_sy) > CMP_BITS'(i_cfg.y_limit)) ?
                  POINT_BITS'(i_cfg.y_limit) : POINT_BITS'(w_sy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld  <= 1'b0;
            r_o_vld  <= 1'b0;
            r_held_x <= '0;
            r_held_y <= '0;
        end else begin
            if (w_p_rdy) begin
                r_p_vld <= i_valid;
            end
            if (w_o_rdy) begin
                r_o_vld <= r_p_vld;
                // hold the last touch point on a released read
                if (r_p_vld && r_p_touch) begin
                    r_held_x <= w_cx;
                    r_held_y <= w_cy;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_p_prod_x <= PROD_BITS'(i_ax) * PROD_BITS'(i_cfg.x_gain);
            r_p_prod_y <= PROD_BITS'(i_ay) * PROD_BITS'(i_cfg.y_gain);
            r_p_touch  <= i_touch;
        end
        if (w_o_rdy && r_p_vld) begin
            r_pressed <= r_p_touch;
        end
    end

    assign o_valid   = r_o_vld;
    assign o_point_x = r_held_x;
    assign o_point_y = r_held_y;
    assign o_pressed = r_pressed;

endmodule

// File: hw/rtl/touch_sample_conditioner_top.sv
// Top level of the touch sample conditioner: register file, front, queue and back.
//
// One read (three rounds of X, Y, Z1, Z2 samples) enters per beat and gives one
// result beat: the held touch point and the pressed flag. Sustained rate is one
// read per clock cycle while the output is not stalled. A result is offered once
// its read has passed the three front stages (sum, reciprocal multiply, correct and
// classify), the queue and the two back stages (gain multiply, clamp and hold). A
// queue of QUEUE_DEPTH reads sits between front and back, so the input keeps
// taking reads while a result is stalled until the back stages, that queue and the
// front stages are full. Registers are written through the plain write port; the
// user writes them only while no read is in flight; the block does not enforce it.
module touch_sample_conditioner_top
    import tsc_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic [SAMPLE_BITS-1:0]   i_x_first,
    input  logic [SAMPLE_BITS-1:0]   i_y_first,
    input  logic [SAMPLE_BITS-1:0]   i_za_first,
    input  logic [SAMPLE_BITS-1:0]   i_zb_first,
    input  logic [SAMPLE_BITS-1:0]   i_x_second,
    input  logic [SAMPLE_BITS-1:0]   i_y_second,
    input  logic [SAMPLE_BITS-1:0]   i_za_second,
    input  logic [SAMPLE_BITS-1:0]   i_zb_second,
    input  logic [SAMPLE_BITS-1:0]   i_x_third,
    input  logic [SAMPLE_BITS-1:0]   i_y_third,
    input  logic [SAMPLE_BITS-1:0]   i_za_third,
    input  logic [SAMPLE_BITS-1:0]   i_zb_third,
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic [POINT_BITS-1:0]    o_point_x,
    output logic [POINT_BITS-1:0]    o_point_y,
    output logic                     o_pressed,
    input  logic                     i_cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int Q_WIDTH = 2 * SAMPLE_BITS + 1;

    t_cfg r_cfg;
    t_cfg n_cfg;

    logic [3:0][ROUNDS-1:0][SAMPLE_BITS-1:0] w_samples;
    logic                   w_push;
    logic                   w_pop;
    logic                   w_q_full;
    logic                   w_q_valid;
    logic [Q_WIDTH-1:0]     w_q_in;
    logic [Q_WIDTH-1:0]     w_q_out;
    logic [SAMPLE_BITS-1:0] w_f_ax;
    logic [SAMPLE_BITS-1:0] w_f_ay;
    logic                   w_f_touch;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_PRESSURE_LIMIT: n_cfg.pressure_limit = i_cfg_data[LIMIT_BITS-1:0];
                CFG_X_GAIN:         n_cfg.x_gain         = i_cfg_data[GAIN_BITS-1:0];
                CFG_Y_GAIN:         n_cfg.y_gain         = i_cfg_data[GAIN_BITS-1:0];
                CFG_X_LIMIT:        n_cfg.x_limit        = i_cfg_data[LIMIT_BITS-1:0];
                CFG_Y_LIMIT:        n_cfg.y_limit        = i_cfg_data[LIMIT_BITS-1:0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pressure_limit <= PRESSURE_LIMIT_RST;
            r_cfg.x_gain         <= X_GAIN_RST;
            r_cfg.y_gain         <= Y_GAIN_RST;
            r_cfg.x_limit        <= X_LIMIT_RST;
            r_cfg.y_limit        <= Y_LIMIT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign w_samples[0] = {i_x_third,  i_x_second,  i_x_first};
    assign w_samples[1] = {i_y_third,  i_y_second,  i_y_first};
    assign w_samples[2] = {i_za_third, i_za_second, i_za_first};
    assign w_samples[3] = {i_zb_third, i_zb_second, i_zb_first};

    tsc_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_samples (w_samples),
        .i_cfg     (r_cfg),
        .i_q_full  (w_q_full),
        .o_push    (w_push),
        .o_ax      (w_f_ax),
        .o_ay      (w_f_ay),
        .o_touch   (w_f_touch)
    );

    assign w_q_in = {w_f_ax, w_f_ay, w_f_touch};

    tsc_queue #(
        .WIDTH (Q_WIDTH),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_q_in),
        .o_full  (w_q_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_out)
    );

    tsc_back #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_q_valid),
        .o_pop     (w_pop),
        .i_ax      (w_q_out[Q_WIDTH-1 -: SAMPLE_BITS]),
        .i_ay      (w_q_out[SAMPLE_BITS:1]),
        .i_touch   (w_q_out[0]),
        .i_cfg     (r_cfg),
        .o_valid   (o_out_valid),
        .i_stall   (i_out_stall),
        .o_point_x (o_point_x),
        .o_point_y (o_point_y),
        .o_pressed (o_pressed)
    );

endmodule

// File: hw/rtl/tsc_checker.sv
// Port-level checker for the touch sample conditioner, bound to the top level.
`include "touch_sample_conditioner_top_assert.svh"

module tsc_checker
    import tsc_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_in_valid,
    input logic                     o_in_stall,
    input logic                     o_out_valid,
    input logic                     i_out_stall,
    input logic [POINT_BITS-1:0]    o_point_x,
    input logic [POINT_BITS-1:0]    o_point_y,
    input logic                     o_pressed,
    input logic                     i_cfg_wr_en,
    input logic [CFG_IDX_BITS-1:0]  i_cfg_index,
    input logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    localparam int CNT_BITS = 4;

    logic                  w_in_acc;
    logic                  w_out_acc;
    logic [CNT_BITS-1:0]   r_inflight;
    logic [POINT_BITS-1:0] r_last_x;
    logic [POINT_BITS-1:0] r_last_y;
    logic [LIMIT_BITS-1:0] r_x_limit;
    logic [LIMIT_BITS-1:0] r_y_limit;

    assign w_in_acc  = i_in_valid && !o_in_stall;
    assign w_out_acc = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
            r_last_x   <= '0;
            r_last_y   <= '0;
            r_x_limit  <= X_LIMIT_RST;
            r_y_limit  <= Y_LIMIT_RST;
        end else begin
            r_inflight <= r_inflight + CNT_BITS'(w_in_acc) - CNT_BITS'(w_out_acc);
            if (w_out_acc) begin
                r_last_x <= o_point_x;
                r_last_y <= o_point_y;
            end
            if (i_cfg_wr_en && i_cfg_index == CFG_X_LIMIT) begin
                r_x_limit <= i_cfg_data[LIMIT_BITS-1:0];
            end
            if (i_cfg_wr_en && i_cfg_index == CFG_Y_LIMIT) begin
                r_y_limit <= i_cfg_data[LIMIT_BITS-1:0];
            end
        end
    end

    `TSC_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_point_x) && $stable(o_point_y) && $stable(o_pressed), "result beat changed while stalled")
    `TSC_ASSERT_NOW(a_no_extra, o_out_valid, r_inflight != '0, "result beat without an accepted read")
    `TSC_ASSERT_NOW(a_release_holds, w_out_acc && !o_pressed, o_point_x == r_last_x && o_point_y == r_last_y, "released read moved the held point")
    `TSC_ASSERT_NOW(a_point_clamped, w_out_acc && o_pressed, o_point_x <= r_x_limit && o_point_y <= r_y_limit, "touch point above its limit")

endmodule

bind touch_sample_conditioner_top tsc_checker u_tsc_checker (.*);
